/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker module.
// Each macro takes a label, the clock, the active-low reset, the
// antecedent, the consequent and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ipv4rx_pkg.sv */
`timescale 1ns / 1ps

package ipv4rx_pkg;

    // Verdict codes given with each finished packet.
    typedef enum logic [3:0] {
        VERDICT_ICMP     = 4'd0,
        VERDICT_UDP      = 4'd1,
        VERDICT_SHORT    = 4'd2,
        VERDICT_VERSION  = 4'd3,
        VERDICT_IHL      = 4'd4,
        VERDICT_TRUNC    = 4'd5,
        VERDICT_CHECKSUM = 4'd6,
        VERDICT_TOTLEN   = 4'd7,
        VERDICT_FRAGMENT = 4'd8,
        VERDICT_NOTOURS  = 4'd9,
        VERDICT_TCP      = 4'd10,
        VERDICT_UNKNOWN  = 4'd11
    } verdict_t;

    // Smallest legal header, in bytes.
    localparam logic [5:0] MIN_HEADER_BYTES = 6'd20;

endpackage

/* hw/rtl/ipv4_rx_header_checker_top.sv */
`timescale 1ns / 1ps

// IPv4 receive header checker. The block takes a received IPv4 packet one
// byte per item on the input channel, header first, with last_byte marking
// the final byte, and gives exactly one result item per packet, built when
// the last byte is processed: a verdict code, the source address, the header
// length in bytes (payload_offset), the payload length and the protocol
// number. Checks are taken in a fixed order (too short, version, IHL,
// truncated header, header checksum, total length, fragment, destination
// address, then protocol dispatch), and payload_length is zero unless the
// packet passed every check. The destination must match own_address, which
// is written through the configuration channel, or be the limited broadcast
// address. The user must write own_address only while no packet is in
// flight; the block does not enforce this. The block sustains one byte per
// clock cycle with no gaps between packets, as long as results are taken
// when offered. Each byte goes through an input register and then a single
// pass of header capture and checksum accumulation into the per-packet
// state, and the result register lets the next packet stream in while a
// verdict waits to be taken. Bytes past 65535 are consumed but not counted.
module ipv4_rx_header_checker_top
    import ipv4rx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] own_address,

    // Byte input channel.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,

    // Result channel.
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  verdict,
    output logic [31:0] source_address,
    output logic [5:0]  payload_offset,
    output logic [15:0] payload_length,
    output logic [7:0]  protocol_number
);

    // Byte positions of the captured header fields.
    localparam logic [15:0] POS_VER_IHL  = 16'd0;
    localparam logic [15:0] POS_LEN_HI   = 16'd2;
    localparam logic [15:0] POS_LEN_LO   = 16'd3;
    localparam logic [15:0] POS_FRAG_HI  = 16'd6;
    localparam logic [15:0] POS_FRAG_LO  = 16'd7;
    localparam logic [15:0] POS_PROTO    = 16'd9;
    localparam logic [15:0] POS_SRC_0    = 16'd12;
    localparam logic [15:0] POS_SRC_1    = 16'd13;
    localparam logic [15:0] POS_SRC_2    = 16'd14;
    localparam logic [15:0] POS_SRC_3    = 16'd15;
    localparam logic [15:0] POS_DST_0    = 16'd16;
    localparam logic [15:0] POS_DST_1    = 16'd17;
    localparam logic [15:0] POS_DST_2    = 16'd18;
    localparam logic [15:0] POS_DST_3    = 16'd19;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
    localparam logic [16:0] SUM_GOOD     = 17'h0FFFF;
    localparam logic [31:0] BROADCAST    = 32'hFFFF_FFFF;
    localparam logic [3:0]  IPV4_VERSION = 4'd4;
    localparam logic [3:0]  IHL_MIN      = 4'd5;
    localparam logic [7:0]  PROTO_ICMP   = 8'd1;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;

    // Configuration register.
    logic [31:0] own_address_reg;

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;

    // Per-packet state.
    logic [15:0] byte_count_reg,     byte_count_next;
    logic [7:0]  version_ihl_reg,    version_ihl_next;
    logic [16:0] sum_acc_reg,        sum_acc_next;
    logic [7:0]  high_byte_reg,      high_byte_next;
    logic [15:0] length_field_reg,   length_field_next;
    logic [15:0] fragment_field_reg, fragment_field_next;
    logic [7:0]  protocol_reg,       protocol_next;
    logic [31:0] source_reg,         source_next;
    logic [31:0] destination_reg,    destination_next;

    // Result register.
    logic        out_valid_reg;
    verdict_t    verdict_reg,        verdict_next;
    logic [31:0] source_address_reg;
    logic [5:0]  payload_offset_reg;
    logic [15:0] payload_length_reg, payload_length_next;
    logic [7:0]  protocol_number_reg;

    logic        advance;
    logic [3:0]  ihl_cur;
    logic [15:0] hlen_cur;
    logic [17:0] sum_wide;
    logic [3:0]  ihl_fin;
    logic [5:0]  hlen_fin;
    logic [15:0] hlen_fin_wide;
    logic        frag_bad;
    logic        dest_bad;

    // The input register moves on whenever it holds a byte that makes no
    // result, or the result register is empty or being drained.
    assign advance   = in_valid_reg && (!in_last_reg || !out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Header capture and checksum accumulation for the byte in the input
    // register. Fields are cleared after every packet, so a plain write is
    // the same as merging into zero.
    always_comb
    begin
        byte_count_next     = byte_count_reg;
        version_ihl_next    = version_ihl_reg;
        sum_acc_next        = sum_acc_reg;
        high_byte_next      = high_byte_reg;
        length_field_next   = length_field_reg;
        fragment_field_next = fragment_field_reg;
        protocol_next       = protocol_reg;
        source_next         = source_reg;
        destination_next    = destination_reg;
        sum_wide            = 18'd0;

        // The header length counts from the first byte itself.
        ihl_cur  = (byte_count_reg == POS_VER_IHL) ? in_data_reg[3:0] : version_ihl_reg[3:0];
        hlen_cur = {10'd0, ihl_cur, 2'b00};

        case (byte_count_reg)
            POS_VER_IHL: version_ihl_next          = in_data_reg;
            POS_LEN_HI:  length_field_next[15:8]   = in_data_reg;
            POS_LEN_LO:  length_field_next[7:0]    = in_data_reg;
            POS_FRAG_HI: fragment_field_next[15:8] = in_data_reg;
            POS_FRAG_LO: fragment_field_next[7:0]  = in_data_reg;
            POS_PROTO:   protocol_next             = in_data_reg;
            POS_SRC_0:   source_next[31:24]        = in_data_reg;
            POS_SRC_1:   source_next[23:16]        = in_data_reg;
            POS_SRC_2:   source_next[15:8]         = in_data_reg;
            POS_SRC_3:   source_next[7:0]          = in_data_reg;
            POS_DST_0:   destination_next[31:24]   = in_data_reg;
            POS_DST_1:   destination_next[23:16]   = in_data_reg;
            POS_DST_2:   destination_next[15:8]    = in_data_reg;
            POS_DST_3:   destination_next[7:0]     = in_data_reg;
            default:     ;
        endcase

        // Even header bytes are held; odd ones complete a 16-bit word that
        // is added with end-around carry.
        if (byte_count_reg < hlen_cur)
        begin
            if (!byte_count_reg[0])
            begin
                high_byte_next = in_data_reg;
            end
            else
            begin
                sum_wide = {1'b0, sum_acc_reg} + {2'b00, high_byte_reg, in_data_reg};
                if (sum_wide > 18'h0FFFF)
                begin
                    sum_wide = {2'b00, sum_wide[15:0]} + 18'd1;
                end
                sum_acc_next = sum_wide[16:0];
            end
        end

        if (byte_count_reg != COUNT_MAX)
        begin
            byte_count_next = byte_count_reg + 16'd1;
        end
    end

    // Verdict, taken from the state as it stands after the last byte.
    always_comb
    begin
        ihl_fin       = version_ihl_next[3:0];
        hlen_fin      = {ihl_fin, 2'b00};
        hlen_fin_wide = {10'd0, hlen_fin};
        frag_bad      = fragment_field_next[13] || (fragment_field_next[12:0] != 13'd0);
        dest_bad      = (destination_next != own_address_reg) && (destination_next != BROADCAST);
        payload_length_next = 16'd0;

        if (byte_count_next < {10'd0, MIN_HEADER_BYTES})
        begin
            verdict_next = VERDICT_SHORT;
        end
        else if (version_ihl_next[7:4] != IPV4_VERSION)
        begin
            verdict_next = VERDICT_VERSION;
        end
        else if (ihl_fin < IHL_MIN)
        begin
            verdict_next = VERDICT_IHL;
        end
        else if (byte_count_next < hlen_fin_wide)
        begin
            verdict_next = VERDICT_TRUNC;
        end
        else if (sum_acc_next != SUM_GOOD)
        begin
            verdict_next = VERDICT_CHECKSUM;
        end
        else if ((length_field_next < hlen_fin_wide) || (byte_count_next < length_field_next))
        begin
            verdict_next = VERDICT_TOTLEN;
        end
        else if (frag_bad)
        begin
            verdict_next = VERDICT_FRAGMENT;
        end
        else if (dest_bad)
        begin
            verdict_next = VERDICT_NOTOURS;
        end
        else
        begin
            case (protocol_next)
                PROTO_ICMP: verdict_next = VERDICT_ICMP;
                PROTO_UDP:  verdict_next = VERDICT_UDP;
                PROTO_TCP:  verdict_next = VERDICT_TCP;
                default:    verdict_next = VERDICT_UNKNOWN;
            endcase
            payload_length_next = length_field_next - hlen_fin_wide;
        end
    end

    // Control and per-packet state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg    <= 32'd0;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            byte_count_reg     <= 16'd0;
            version_ihl_reg    <= 8'd0;
            sum_acc_reg        <= 17'd0;
            high_byte_reg      <= 8'd0;
            length_field_reg   <= 16'd0;
            fragment_field_reg <= 16'd0;
            protocol_reg       <= 8'd0;
            source_reg         <= 32'd0;
            destination_reg    <= 32'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                own_address_reg <= own_address;
            end

            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end

            if (advance && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                if (in_last_reg)
                begin
                    // Packet done: start the next one from a clean state.
                    byte_count_reg     <= 16'd0;
                    version_ihl_reg    <= 8'd0;
                    sum_acc_reg        <= 17'd0;
                    high_byte_reg      <= 8'd0;
                    length_field_reg   <= 16'd0;
                    fragment_field_reg <= 16'd0;
                    protocol_reg       <= 8'd0;
                    source_reg         <= 32'd0;
                    destination_reg    <= 32'd0;
                end
                else
                begin
                    byte_count_reg     <= byte_count_next;
                    version_ihl_reg    <= version_ihl_next;
                    sum_acc_reg        <= sum_acc_next;
                    high_byte_reg      <= high_byte_next;
                    length_field_reg   <= length_field_next;
                    fragment_field_reg <= fragment_field_next;
                    protocol_reg       <= protocol_next;
                    source_reg         <= source_next;
                    destination_reg    <= destination_next;
                end
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= data_byte;
            in_last_reg <= last_byte;
        end

        if (advance && in_last_reg)
        begin
            verdict_reg         <= verdict_next;
            source_address_reg  <= source_next;
            payload_offset_reg  <= hlen_fin;
            payload_length_reg  <= payload_length_next;
            protocol_number_reg <= protocol_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign verdict         = verdict_reg;
    assign source_address  = source_address_reg;
    assign payload_offset  = payload_offset_reg;
    assign payload_length  = payload_length_reg;
    assign protocol_number = protocol_number_reg;

endmodule

/* hw/rtl/ipv4rx_checker.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Checks on the result channel of the header checker, seen at its ports.
module ipv4rx_checker
    import ipv4rx_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  verdict,
    input logic [5:0]  payload_offset,
    input logic [15:0] payload_length
);

    logic passed;

    // A packet that passed every check ends in protocol dispatch.
    assign passed = (verdict == VERDICT_ICMP) || (verdict == VERDICT_UDP) ||
                    (verdict == VERDICT_TCP) || (verdict == VERDICT_UNKNOWN);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

    `ASSERT_SAME(a_plen_zero, clk, rst_n, out_valid && !passed, payload_length == 16'd0, "payload length on rejected packet")

    `ASSERT_SAME(a_offset_aligned, clk, rst_n, out_valid, payload_offset[1:0] == 2'b00, "payload offset not a multiple of four")

    `ASSERT_SAME(a_pass_header, clk, rst_n, out_valid && passed, payload_offset >= MIN_HEADER_BYTES, "accepted packet with short header")

endmodule

bind ipv4_rx_header_checker_top ipv4rx_checker u_ipv4rx_checker (.*);
